/* design/vprl_pkg.sv */
// ----------------------------------------------------------------------------
// vprl_pkg: shared types and helpers for the rate limited velocity PID
// Holds the sequencer state type, register map, fixed weights and saturation.
// ----------------------------------------------------------------------------
package vprl_pkg;

  localparam logic signed [31:0] WEIGHT_P        = 32'sd65536;
  localparam logic signed [31:0] WEIGHT_D        = 32'sd65536;
  localparam logic signed [31:0] ANTIWINDUP_GAIN = 32'sd6554;

  localparam int DATA_W = 32;
  localparam int PROD_W = 48;   // product after the Q16 shift
  localparam int WIDE_W = 50;   // headroom for sums before saturation

  localparam logic signed [WIDE_W-1:0] S32_MAX = WIDE_W'(64'sh7FFF_FFFF);
  localparam logic signed [WIDE_W-1:0] S32_MIN = -WIDE_W'(64'sh8000_0000);

  typedef enum logic [2:0] {
    REG_PROP_GAIN     = 3'd0,
    REG_INTEGRAL_GAIN = 3'd1,
    REG_DERIV_POLE    = 3'd2,
    REG_DERIV_GAIN    = 3'd3,
    REG_RATE_UP       = 3'd4,
    REG_RATE_DOWN     = 3'd5,
    REG_OUT_UPPER     = 3'd6,
    REG_OUT_LOWER     = 3'd7
  } cfg_reg_t;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_WP    = 12'b0000_0000_0010,
    ST_WD    = 12'b0000_0000_0100,
    ST_PROP  = 12'b0000_0000_1000,
    ST_INT   = 12'b0000_0001_0000,
    ST_AW    = 12'b0000_0010_0000,
    ST_POLE  = 12'b0000_0100_0000,
    ST_DGAIN = 12'b0000_1000_0000,
    ST_DD    = 12'b0001_0000_0000,
    ST_SUM   = 12'b0010_0000_0000,
    ST_RATE  = 12'b0100_0000_0000,
    ST_LIM   = 12'b1000_0000_0000
  } state_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] x);
    logic signed [DATA_W-1:0] r;
    if (x > S32_MAX) r = 32'sh7FFF_FFFF;
    else if (x < S32_MIN) r = 32'sh8000_0000;
    else r = x[DATA_W-1:0];
    return r;
  endfunction

endpackage

/* design/vprl_mul.sv */
// ----------------------------------------------------------------------------
// vprl_mul: registered Q16.16 multiplier
// Signed 32x32 product, arithmetic shift right by 16 (floor), registered.
// ----------------------------------------------------------------------------
module vprl_mul (
  input  logic                                clk,
  input  logic signed [vprl_pkg::DATA_W-1:0]  a,
  input  logic signed [vprl_pkg::DATA_W-1:0]  b,
  output logic signed [vprl_pkg::PROD_W-1:0]  q
);
  import vprl_pkg::*;

  logic signed [2*DATA_W-1:0] prod;

  assign prod = a * b;

  always_ff @(posedge clk) begin
    q <= prod[2*DATA_W-1:16];
  end

endmodule

/* design/velocity_pid_rate_limited_core.sv */
// ----------------------------------------------------------------------------
// velocity_pid_rate_limited_core: incremental PID with rate and value limits
// Q16.16 velocity-form PID, setpoint weighting, filtered derivative,
// back-calculation anti-windup, actuator rate clamp and output clamp.
// ----------------------------------------------------------------------------
// One item is worked at a time through a single shared multiplier under a
// small sequencer. A control step issues seven products back to back, then
// the sum, rate clamp and output clamp; a start item goes from the weighted
// setpoint products straight to the commit. The result sits in an output
// register, so a new item is taken while it waits; the final state holds only
// if the previous result is still not taken. Configuration registers may be
// written at any idle time and read back through the APB port.
module velocity_pid_rate_limited_core (
  input  logic         clk,
  input  logic         rst,
  // APB configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // input stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,   // process_value, setpoint, start_value
  input  logic         s_tuser,   // kind (0 start, 1 step)
  // result stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata    // actuator_out, control_out
);
  import vprl_pkg::*;

  // configuration
  logic [30:0]               prop_gain;
  logic [30:0]               integral_gain;
  logic [16:0]               deriv_pole;
  logic [30:0]               deriv_gain;
  logic [30:0]               rate_up_limit;
  logic signed [DATA_W-1:0]  rate_down_limit;
  logic signed [DATA_W-1:0]  out_upper;
  logic signed [DATA_W-1:0]  out_lower;

  // controller state
  logic signed [DATA_W-1:0]  prop_err_prev;
  logic signed [DATA_W-1:0]  deriv_err_prev1;
  logic signed [DATA_W-1:0]  deriv_err_prev2;
  logic signed [DATA_W-1:0]  deriv_incr_prev;
  logic signed [DATA_W-1:0]  control_acc;
  logic signed [DATA_W-1:0]  actuator_acc;

  // working registers
  state_t                    state;
  logic                      kind;
  logic signed [DATA_W-1:0]  pv;
  logic signed [DATA_W-1:0]  sp;
  logic signed [DATA_W-1:0]  sv;
  logic signed [DATA_W-1:0]  ie;
  logic signed [DATA_W-1:0]  pe;
  logic signed [DATA_W-1:0]  de;
  logic signed [DATA_W-1:0]  d2s;
  logic signed [DATA_W-1:0]  dp;
  logic signed [DATA_W-1:0]  di;
  logic signed [DATA_W-1:0]  dd;
  logic signed [PROD_W-1:0]  acc;
  logic signed [DATA_W-1:0]  ca_new;
  logic signed [DATA_W-1:0]  chg;
  logic signed [DATA_W-1:0]  actuator_out;
  logic signed [DATA_W-1:0]  control_out;

  logic signed [DATA_W-1:0]  mul_a;
  logic signed [DATA_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]  mul_q;

  logic                      cfg_wr;
  cfg_reg_t                  cfg_sel;
  logic                      out_free;
  logic                      result_load;
  logic signed [32:0]        change_raw;
  logic signed [32:0]        change_lim;
  logic signed [32:0]        act_raw;
  logic signed [32:0]        act_lim;

  vprl_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .q   (mul_q)
  );

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign cfg_sel  = cfg_reg_t'(paddr[4:2]);
  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign result_load = (state == ST_LIM) && out_free;
  assign m_tdata  = {control_out, actuator_out};

  always_comb begin
    unique case (cfg_sel)
      REG_PROP_GAIN:     prdata = {1'b0, prop_gain};
      REG_INTEGRAL_GAIN: prdata = {1'b0, integral_gain};
      REG_DERIV_POLE:    prdata = {15'd0, deriv_pole};
      REG_DERIV_GAIN:    prdata = {1'b0, deriv_gain};
      REG_RATE_UP:       prdata = {1'b0, rate_up_limit};
      REG_RATE_DOWN:     prdata = rate_down_limit;
      REG_OUT_UPPER:     prdata = out_upper;
      REG_OUT_LOWER:     prdata = out_lower;
      default:           prdata = '0;
    endcase
  end

  // operand select for the product issued in each state
  always_comb begin
    unique case (state)
      ST_WP:    begin mul_a = WEIGHT_P; mul_b = sp; end
      ST_WD:    begin mul_a = WEIGHT_D; mul_b = sp; end
      ST_PROP:  begin
        mul_a = {1'b0, prop_gain};
        mul_b = sat32(WIDE_W'(pe) - WIDE_W'(prop_err_prev));
      end
      ST_INT:   begin mul_a = {1'b0, integral_gain}; mul_b = ie; end
      ST_AW:    begin
        mul_a = ANTIWINDUP_GAIN;
        mul_b = sat32(WIDE_W'(actuator_acc) - WIDE_W'(control_acc));
      end
      ST_POLE:  begin mul_a = {15'd0, deriv_pole}; mul_b = deriv_incr_prev; end
      ST_DGAIN: begin mul_a = {1'b0, deriv_gain}; mul_b = d2s; end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // rate clamp: upper test first
  always_comb begin
    change_raw = 33'(ca_new) - 33'(actuator_acc);
    if (change_raw > $signed({2'b00, rate_up_limit})) change_lim = {2'b00, rate_up_limit};
    else if (change_raw < 33'(rate_down_limit)) change_lim = 33'(rate_down_limit);
    else change_lim = change_raw;
  end

  // output clamp: upper test first
  always_comb begin
    act_raw = 33'(actuator_acc) + 33'(chg);
    if (act_raw > 33'(out_upper)) act_lim = 33'(out_upper);
    else if (act_raw < 33'(out_lower)) act_lim = 33'(out_lower);
    else act_lim = act_raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain       <= 31'd65536;
      integral_gain   <= '0;
      deriv_pole      <= '0;
      deriv_gain      <= '0;
      rate_up_limit   <= 31'h7FFF_FFFF;
      rate_down_limit <= 32'sh8000_0000;
      out_upper       <= 32'sh7FFF_FFFF;
      out_lower       <= 32'sh8000_0000;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_PROP_GAIN:     prop_gain       <= pwdata[30:0];
        REG_INTEGRAL_GAIN: integral_gain   <= pwdata[30:0];
        REG_DERIV_POLE:    deriv_pole      <= pwdata[16:0];
        REG_DERIV_GAIN:    deriv_gain      <= pwdata[30:0];
        REG_RATE_UP:       rate_up_limit   <= pwdata[30:0];
        REG_RATE_DOWN:     rate_down_limit <= pwdata;
        REG_OUT_UPPER:     out_upper       <= pwdata;
        REG_OUT_LOWER:     out_lower       <= pwdata;
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      m_tvalid        <= 1'b0;
      prop_err_prev   <= '0;
      deriv_err_prev1 <= '0;
      deriv_err_prev2 <= '0;
      deriv_incr_prev <= '0;
      control_acc     <= '0;
      actuator_acc    <= '0;
    end else begin
      if (m_tvalid && m_tready && !result_load) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            kind  <= s_tuser;
            pv    <= s_tdata[31:0];
            sp    <= s_tdata[63:32];
            sv    <= s_tdata[95:64];
            state <= ST_WP;
          end
        end
        ST_WP: begin
          ie    <= sat32(WIDE_W'(sp) - WIDE_W'(pv));
          state <= ST_WD;
        end
        ST_WD: begin
          pe    <= sat32(WIDE_W'(mul_q) - WIDE_W'(pv));
          state <= ST_PROP;
        end
        ST_PROP: begin
          de    <= sat32(WIDE_W'(mul_q) - WIDE_W'(pv));
          state <= kind ? ST_INT : ST_LIM;
        end
        ST_INT: begin
          dp    <= sat32(WIDE_W'(mul_q));
          d2s   <= sat32(WIDE_W'(de) - (WIDE_W'(deriv_err_prev1) <<< 1)
                         + WIDE_W'(deriv_err_prev2));
          state <= ST_AW;
        end
        ST_AW: begin
          acc   <= mul_q;
          state <= ST_POLE;
        end
        ST_POLE: begin
          di    <= sat32(WIDE_W'(acc) + WIDE_W'(mul_q));
          state <= ST_DGAIN;
        end
        ST_DGAIN: begin
          acc   <= mul_q;
          state <= ST_DD;
        end
        ST_DD: begin
          dd    <= sat32(WIDE_W'(acc) + WIDE_W'(mul_q));
          state <= ST_SUM;
        end
        ST_SUM: begin
          ca_new <= sat32(WIDE_W'(control_acc) + WIDE_W'(dp) + WIDE_W'(di) + WIDE_W'(dd));
          state  <= ST_RATE;
        end
        ST_RATE: begin
          // in range once clamped
          chg   <= change_lim[DATA_W-1:0];
          state <= ST_LIM;
        end
        ST_LIM: begin
          // commit only when the result register can take the item
          if (out_free) begin
            prop_err_prev   <= pe;
            deriv_err_prev1 <= de;
            m_tvalid        <= 1'b1;
            state           <= ST_IDLE;
            if (kind) begin
              deriv_err_prev2 <= deriv_err_prev1;
              deriv_incr_prev <= dd;
              control_acc     <= ca_new;
              actuator_acc    <= act_lim[DATA_W-1:0];
              control_out     <= ca_new;
              actuator_out    <= act_lim[DATA_W-1:0];
            end else begin
              deriv_err_prev2 <= de;
              deriv_incr_prev <= '0;
              control_acc     <= sv;
              actuator_acc    <= sv;
              control_out     <= sv;
              actuator_out    <= sv;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* design/vprl_checker.sv */
// ----------------------------------------------------------------------------
// vprl_checker: port level checks for the rate limited velocity PID
// Watches the stream handshakes and the one-item-at-a-time sequencing.
// ----------------------------------------------------------------------------
module vprl_port_asserts (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready
);

  // a result that is not taken stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped before it was taken");

  // one item in flight: no second accept right after the first
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an item is in progress");

  // no result appears in the ST_WP and ST_WD states of an item entering an empty block
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (!m_tvalid || m_tready) |=> !m_tvalid ##1 !m_tvalid)
    else $error("result appeared too early");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind velocity_pid_rate_limited_core vprl_port_asserts u_vprl_checker (.*);

/* tb/sv/vprl_checker.sv */
// ----------------------------------------------------------------------------
// vprl_checker: result predictor and scoreboard for the rate limited PID core
// Snoops APB register writes and the input stream, predicts each item's
// actuator and control values in Q16.16, and compares them with the results.
// ----------------------------------------------------------------------------
module vprl_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [95:0]  s_tdata,   // process_value, setpoint, start_value
  input  logic         s_tuser,   // kind (0 start, 1 step)
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [63:0]  m_tdata,   // actuator_out, control_out
  output int           fail_count,
  output int           open_count,
  output int           start_count,
  output int           step_count,
  output int           checked_count
);
  import vprl_pkg::*;

  typedef struct packed {
    logic [31:0] control;
    logic [31:0] actuator;
  } drive_t;

  drive_t pending_drive[$];
  drive_t got, want;

  // register copies
  longint kp, ki, pole, kd, rise_max, fall_min, act_hi, act_lo;
  // loop state
  longint prop_err_last, deriv_err_last, deriv_err_older, deriv_incr_last;
  longint ctrl_acc, act_acc;

  function automatic longint clip32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint sx32(input logic [31:0] v);
    return longint'($signed(v));
  endfunction

  // Q16.16 product, floor shift
  function automatic longint qmul(input longint a, input longint b);
    return (a * b) >>> 16;
  endfunction

  function automatic drive_t advance_loop(input logic is_step, input logic [95:0] bits);
    longint pv, sp, pe, de, ie, dp, di, d2, dd, change, act;
    drive_t r;
    pv = sx32(bits[31:0]);
    sp = sx32(bits[63:32]);
    pe = clip32(qmul(WEIGHT_P, sp) - pv);
    de = clip32(qmul(WEIGHT_D, sp) - pv);
    if (!is_step) begin
      prop_err_last   = pe;
      deriv_err_last  = de;
      deriv_err_older = de;
      deriv_incr_last = 0;
      ctrl_acc        = sx32(bits[95:64]);
      act_acc         = ctrl_acc;
    end else begin
      ie = clip32(sp - pv);
      dp = clip32(qmul(kp, clip32(pe - prop_err_last)));
      di = clip32(qmul(ki, ie) + qmul(ANTIWINDUP_GAIN, clip32(act_acc - ctrl_acc)));
      d2 = clip32(de - 2 * deriv_err_last + deriv_err_older);
      dd = clip32(qmul(pole, deriv_incr_last) + qmul(kd, d2));
      ctrl_acc = clip32(ctrl_acc + dp + di + dd);
      // upper tests first: with crossed limits a value above the upper one takes it, any other takes the lower one
      change = ctrl_acc - act_acc;
      if (change > rise_max) change = rise_max;
      else if (change < fall_min) change = fall_min;
      act = act_acc + change;
      if (act > act_hi) act = act_hi;
      else if (act < act_lo) act = act_lo;
      act_acc = clip32(act);
      deriv_incr_last = dd;
      deriv_err_older = deriv_err_last;
      deriv_err_last  = de;
      prop_err_last   = pe;
    end
    r.actuator = act_acc[31:0];
    r.control  = ctrl_acc[31:0];
    return r;
  endfunction

  task automatic note_fail(input string what, input logic [31:0] exp_v, input logic [31:0] act_v);
    fail_count++;
    if (fail_count <= 10)
      $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, what, exp_v, act_v);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      kp = 65536; ki = 0; pole = 0; kd = 0;
      rise_max = 64'sd2147483647; fall_min = -64'sd2147483648;
      act_hi   = 64'sd2147483647; act_lo   = -64'sd2147483648;
      prop_err_last = 0; deriv_err_last = 0; deriv_err_older = 0;
      deriv_incr_last = 0; ctrl_acc = 0; act_acc = 0;
      pending_drive.delete();
      fail_count = 0; start_count = 0; step_count = 0; checked_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_t'(paddr[4:2]))
          REG_PROP_GAIN:     kp       = longint'(pwdata[30:0]);
          REG_INTEGRAL_GAIN: ki       = longint'(pwdata[30:0]);
          REG_DERIV_POLE:    pole     = longint'(pwdata[16:0]);
          REG_DERIV_GAIN:    kd       = longint'(pwdata[30:0]);
          REG_RATE_UP:       rise_max = longint'(pwdata[30:0]);
          REG_RATE_DOWN:     fall_min = sx32(pwdata);
          REG_OUT_UPPER:     act_hi   = sx32(pwdata);
          REG_OUT_LOWER:     act_lo   = sx32(pwdata);
          default: ;
        endcase
      end
      // results first: the output is registered, so a result never belongs
      // to an item taken at the same edge
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (pending_drive.size() == 0) begin
          note_fail("unexpected result (actuator)", 32'hx, got.actuator);
        end else begin
          want = pending_drive.pop_front();
          checked_count++;
          if (got.actuator !== want.actuator) note_fail("actuator_out", want.actuator, got.actuator);
          if (got.control !== want.control) note_fail("control_out", want.control, got.control);
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser) step_count++;
        else start_count++;
        pending_drive.push_back(advance_loop(s_tuser, s_tdata));
      end
    end
    open_count = pending_drive.size();
  end

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for velocity_pid_rate_limited_core
// Drives start and step items under several register settings with random
// gaps and output stalls; a side checker predicts and scores every result.
// ----------------------------------------------------------------------------
module tb_top;
  import vprl_pkg::*;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;
  localparam int   PHASES     = 9;
  localparam int   PHASE_ITEMS = 180;
  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [95:0]  s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;

  int fail_count, open_count, start_count, step_count, checked_count;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  logic squeeze_req = 1'b0;
  logic [31:0] sp_walk, pv_walk;

  always #5 clk = ~clk;

  velocity_pid_rate_limited_core dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  vprl_checker chk (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .open_count(open_count), .start_count(start_count),
    .step_count(step_count), .checked_count(checked_count)
  );

  initial begin
    #8_000_000;
    $display("run timed out with %0d results outstanding", open_count);
    $display("TB_ERROR");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : rx_side
    int n;
    bit squeezed;
    squeezed = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze_req && !squeezed) begin
        squeezed = 1'b1;
        m_tready = 1'b0;
        repeat (400) @(negedge clk);
      end else if (int'($urandom_range(99)) < rx_idle_pct) begin
        n = $urandom_range(1, 11);
        m_tready = 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        n = $urandom_range(1, 16);
        m_tready = 1'b1;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  function automatic logic [31:0] jitter();
    int j;
    j = $urandom_range(0, 262144);
    return j - 131072;
  endfunction

  function automatic logic [31:0] pick_q();
    int sel;
    int v;
    sel = $urandom_range(9);
    case (sel)
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(4))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return 32'h0;
          3: return 32'hFFFF_FFFF;
          default: return 32'h1;
        endcase
      end
      3, 4: begin
        v = $urandom_range(0, 134217728);
        return v - 67108864;
      end
      default: begin
        v = $urandom_range(0, 2097152);
        return v - 1048576;
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    if ($urandom_range(1) != 0) return $urandom;
    return $urandom_range(0, 32'h0004_0000);
  endfunction

  task automatic push_item(input logic kind, input logic [31:0] pv, input logic [31:0] sp,
                           input logic [31:0] sv);
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser  = kind;
    s_tdata  = {sv, sp, pv};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic pause_tx(input int n);
    @(negedge clk);
    s_tvalid = 1'b0;
    s_tdata  = {$urandom, $urandom, $urandom};
    s_tuser  = $urandom_range(1);
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [31:0] val);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic program_regs(input logic [31:0] kp, input logic [31:0] ki,
                              input logic [31:0] pole, input logic [31:0] kd,
                              input logic [31:0] up, input logic [31:0] dn,
                              input logic [31:0] hi, input logic [31:0] lo);
    cfg_write(REG_PROP_GAIN, kp);
    cfg_write(REG_INTEGRAL_GAIN, ki);
    cfg_write(REG_DERIV_POLE, pole);
    cfg_write(REG_DERIV_GAIN, kd);
    cfg_write(REG_RATE_UP, up);
    cfg_write(REG_RATE_DOWN, dn);
    cfg_write(REG_OUT_UPPER, hi);
    cfg_write(REG_OUT_LOWER, lo);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (open_count != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // mostly a plant-like walk around the setpoint, with occasional restarts
  task automatic random_item();
    if ($urandom_range(99) < 3) begin
      sp_walk = pick_q();
      pv_walk = sp_walk + jitter();
      push_item(KIND_START, pv_walk, sp_walk, pick_q());
    end else begin
      if ($urandom_range(9) == 0) sp_walk = pick_q();
      case ($urandom_range(19))
        0, 1, 2:       pv_walk = pick_q();
        3, 4, 5, 6, 7: pv_walk = sp_walk + jitter();
        default:       pv_walk = pv_walk + jitter();
      endcase
      push_item(KIND_STEP, pv_walk, sp_walk, $urandom);
    end
    if (int'($urandom_range(99)) < tx_idle_pct) pause_tx($urandom_range(1, 11));
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // reset settings: unity proportional gain, open limits
    push_item(KIND_STEP, 32'h0, 32'h0, $urandom);   // step straight out of reset
    push_item(KIND_STEP, Q_MAX, Q_MIN, 32'h0);
    push_item(KIND_STEP, Q_MIN, Q_MAX, Q_MAX);
    push_item(KIND_STEP, Q_MIN, Q_MAX, Q_MIN);
    push_item(KIND_START, 32'h1, 32'hFFFF_FFFF, Q_MAX);
    push_item(KIND_STEP, 32'h0, 32'h0001_0000, 32'h0);
    push_item(KIND_STEP, Q_MAX, Q_MAX, 32'h0);
    push_item(KIND_START, Q_MAX, Q_MIN, Q_MIN);
    push_item(KIND_STEP, Q_MIN, Q_MAX, 32'hFFFF_FFFF);
    push_item(KIND_STEP, 32'h0, 32'h0, 32'h0);
    push_item(KIND_START, 32'h0, 32'h0, 32'h0);
    push_item(KIND_STEP, 32'hFFFF_FFFF, 32'h1, 32'h0);
    push_item(KIND_STEP, 32'h0001_0000, 32'h0001_0000, 32'h0);

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_drained();
        case (p)
          1: program_regs(32'h0001_0000, 32'h0000_199A, 32'h0000_8000, 32'h0000_3333,
                          32'h0002_0000, 32'hFFFE_0000, 32'h0064_0000, 32'hFF9C_0000);
          // maximal gains, derivative pole above one, zero rate window
          2: program_regs(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0001_FFFF, 32'h7FFF_FFFF,
                          32'h0, 32'h0, Q_MAX, Q_MIN);
          // crossed rate limits and crossed output limits
          3: program_regs(32'h0002_0000, 32'h0000_8000, 32'h0000_E666, 32'h0000_4CCD,
                          32'h0000_8000, 32'h0002_0000, 32'hFFFB_0000, 32'h0005_0000);
          4: program_regs(32'h0, 32'h0, 32'h0, 32'h0, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
          8: program_regs(32'h0000_C000, 32'h0000_0CCD, 32'h0000_4000, 32'h0000_2000,
                          32'h0000_4000, 32'hFFFF_8000, 32'h0010_0000, 32'hFFF0_0000);
          default: program_regs(pick_gain(), pick_gain(), $urandom, pick_gain(),
                                $urandom, $urandom, pick_q(), pick_q());
        endcase
      end
      tx_idle_pct = (p == PHASES - 1 || p == 1) ? 0 : ((p % 3 == 0) ? 15 : 35);
      rx_idle_pct = (p == PHASES - 1) ? 0 : ((p % 3 == 2) ? 10 : 35);
      squeeze_req = (p == 1);
      sp_walk = pick_q();
      pv_walk = sp_walk + jitter();
      push_item(KIND_START, pv_walk, sp_walk, pick_q());
      for (int i = 0; i < PHASE_ITEMS; i++) random_item();
    end

    @(negedge clk);
    s_tvalid = 1'b0;
    while (open_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d start items and %0d control steps over %0d register settings",
             start_count, step_count, PHASES);
    $display("%0d results compared, %0d mismatches", checked_count, fail_count);
    if (fail_count == 0 && open_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
